/* src/gauss_elimination_solver_core_macros.svh */
// ----------------------------------------------------------------------------
// Gauss elimination solver assertion macros
// Shared property shapes for the solver checker.
// ----------------------------------------------------------------------------
`ifndef GAUSS_ELIMINATION_SOLVER_CORE_MACROS_SVH
`define GAUSS_ELIMINATION_SOLVER_CORE_MACROS_SVH

// An antecedent seen at one edge implies a consequent at the next edge.
`define GJE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// A condition that must never be seen at any edge.
`define GJE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        !(cond)) else $error(msg);

`endif

/* src/gje_pkg.sv */
// ----------------------------------------------------------------------------
// Gauss elimination solver package
// Sizes, types, state codes and saturating helpers shared by the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package gje_pkg;

    localparam int MAX_UNKNOWNS = 8;
    localparam int WORD_BITS    = 48;
    localparam int FRAC_BITS    = 32;
    localparam int HALF_BITS    = WORD_BITS / 2;
    localparam int ROW_CELLS    = MAX_UNKNOWNS + 1;
    localparam int STORE_DEPTH  = MAX_UNKNOWNS * ROW_CELLS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int LOAD_W       = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W        = $clog2(ROW_CELLS + 1);
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
    localparam int SIZE_W       = 4;
    localparam int THR_W        = 47;
    localparam int OUT_IDX_W    = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int DIV_ITER     = WORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_ITER);

    localparam logic [SIZE_W-1:0] SIZE_RESET      = 4'd8;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 47'd42950;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        mag_t;

    typedef struct packed {
        logic  done;
        word_t value;
    } arith_res_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_IN_USE     = 2'd0,
        CFG_PIVOT_THRESHOLD = 2'd1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COL,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FILL_RD,
        ST_FILL_SH,
        ST_CP_RD,
        ST_CP_WR,
        ST_NORM,
        ST_NDIV,
        ST_EL_T,
        ST_EL_F,
        ST_EL_RD,
        ST_EL_OP,
        ST_EL_MW,
        ST_BS_ROW,
        ST_BS_X,
        ST_BS_C,
        ST_BS_RD,
        ST_BS_MW,
        ST_OUT
    } solve_state_t;

    function automatic mag_t mag_of(input word_t v);
        mag_t m;
        m = v[WORD_BITS-1] ? mag_t'(-v) : mag_t'(v);
        return m;
    endfunction

    function automatic word_t sat_word(input logic neg, input logic ovf,
                                       input logic [WORD_BITS-2:0] m);
        mag_t full;
        word_t y;
        full = {1'b0, m};
        if (ovf) begin
            y = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (neg) begin
            y = word_t'(~full + mag_t'(1));
        end else begin
            y = word_t'(full);
        end
        return y;
    endfunction

    function automatic word_t sub_sat(input word_t a, input word_t b);
        logic [WORD_BITS:0] d;
        word_t y;
        d = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (d[WORD_BITS] != d[WORD_BITS-1]) begin
            y = sat_word(d[WORD_BITS], 1'b1, '0);
        end else begin
            y = word_t'(d[WORD_BITS-1:0]);
        end
        return y;
    endfunction

endpackage

`default_nettype wire

/* src/gauss_elimination_solver_core.sv */
// ----------------------------------------------------------------------------
// Gauss elimination solver core
// Loads an augmented matrix, solves it with partial pivoting, emits x.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_       in         one augmented entry, row-major, final mark
//  m_       out        one solution element with index and last mark
//  cfg_     in         register index and write data
//
//  Load beats are accepted while idle; the beat with the final mark starts the solve.
//  Every normalizing divide runs on the one shared divider and every multiply
//  on the one shared multiplier.
//  The pivot row travels through a chain of MAX_UNKNOWNS+1 word cells.
//  Input is stalled from the final beat until the last solution beat leaves.
//  Reset is synchronous; it idles control, clears the load count, presets size and threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module gauss_elimination_solver_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire gje_pkg::word_t                     s_entry_value,
    input  wire logic                               s_final_entry,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [gje_pkg::OUT_IDX_W-1:0]           m_unknown_index,
    output gje_pkg::word_t                          m_unknown_value,
    output logic                                    m_last_unknown,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gje_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gje_pkg::THR_W-1:0]          cfg_data
);

    localparam int CW = gje_pkg::CNT_W;
    localparam int D  = gje_pkg::ROW_CELLS;

    gje_pkg::solve_state_t           state_reg;
    gje_pkg::solve_state_t           state_next;
    logic [gje_pkg::SIZE_W-1:0]      size_reg;
    logic [gje_pkg::THR_W-1:0]       thr_reg;
    logic [gje_pkg::LOAD_W-1:0]      load_reg;
    logic [CW-1:0]                   row_reg;
    logic [CW-1:0]                   t_reg;
    logic [CW-1:0]                   col_reg;
    logic [CW-1:0]                   bi_reg;
    logic [CW-1:0]                   out_reg;
    gje_pkg::mag_t                   best_reg;
    gje_pkg::word_t                  piv_reg;
    gje_pkg::word_t                  f_reg;
    gje_pkg::word_t                  x_reg;
    gje_pkg::word_t                  rdata_reg;
    gje_pkg::word_t                  sol_reg [gje_pkg::MAX_UNKNOWNS];
    gje_pkg::word_t                  aug_mem [gje_pkg::STORE_DEPTH];

    logic [CW-1:0]                   n_eff;
    logic [CW-1:0]                   w_eff;
    logic [gje_pkg::LOAD_W-1:0]      total;
    logic                            skip;
    logic                            norm_act;
    logic                            el_act;
    logic                            col_end;
    logic                            load_ok;
    gje_pkg::mag_t                   cand_mag;

    logic                            mem_we;
    logic [gje_pkg::ADDR_W-1:0]      mem_waddr;
    logic [gje_pkg::ADDR_W-1:0]      mem_raddr;
    gje_pkg::word_t                  mem_wdata;
    logic                            mul_start;
    logic                            div_start;
    logic                            shift_en;
    gje_pkg::word_t                  feed;
    gje_pkg::word_t                  head;
    gje_pkg::word_t                  mul_a;
    gje_pkg::word_t                  mul_b;
    gje_pkg::word_t                  el_diff;
    gje_pkg::arith_res_t             mul_res;
    gje_pkg::arith_res_t             div_res;
    gje_pkg::word_t                  cell_q [D];

    function automatic logic [gje_pkg::ADDR_W-1:0] addr_of(
        input logic [CW-1:0] r, input logic [CW-1:0] c, input logic [CW-1:0] w);
        int a;
        a = int'(r) * int'(w) + int'(c);
        return gje_pkg::ADDR_W'(a);
    endfunction

    always_comb begin
        if (size_reg == '0) begin
            n_eff = CW'(1);
        end else if (int'(size_reg) > gje_pkg::MAX_UNKNOWNS) begin
            n_eff = CW'(gje_pkg::MAX_UNKNOWNS);
        end else begin
            n_eff = CW'(size_reg);
        end
        w_eff    = n_eff + CW'(1);
        total    = gje_pkg::LOAD_W'(int'(n_eff) * int'(w_eff));
        load_ok  = load_reg < total;
        skip     = (best_reg < gje_pkg::mag_t'(thr_reg)) || (best_reg == '0);
        norm_act = (col_reg < w_eff) && (col_reg >= row_reg) && !skip;
        el_act   = (col_reg < w_eff) && (col_reg >= row_reg);
        col_end  = col_reg == CW'(D - 1);
        cand_mag = gje_pkg::mag_of(rdata_reg);
        el_diff  = gje_pkg::sub_sat(rdata_reg, mul_res.value);
    end

    // Pivot row chain.
    assign head = cell_q[0];
    for (genvar i = 0; i < D; i++) begin : g_cell
        gje_pkg::word_t cell_in;
        if (i == D - 1) begin : g_last
            assign cell_in = feed;
        end else begin : g_mid
            assign cell_in = cell_q[i+1];
        end
        gje_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .din      (cell_in),
            .dout     (cell_q[i])
        );
    end

    gje_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .res     (mul_res)
    );

    gje_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (head),
        .b       (piv_reg),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            aug_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= aug_mem[mem_raddr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gje_pkg::ST_IDLE: begin
                if (s_valid && s_final_entry) begin
                    state_next = gje_pkg::ST_COL;
                end
            end
            gje_pkg::ST_COL: begin
                state_next = (row_reg == n_eff) ? gje_pkg::ST_BS_ROW : gje_pkg::ST_SRCH_RD;
            end
            gje_pkg::ST_SRCH_RD:  state_next = gje_pkg::ST_SRCH_CMP;
            gje_pkg::ST_SRCH_CMP: begin
                state_next = (t_reg == n_eff - CW'(1)) ? gje_pkg::ST_FILL_RD
                                                        : gje_pkg::ST_SRCH_RD;
            end
            gje_pkg::ST_FILL_RD:  state_next = gje_pkg::ST_FILL_SH;
            gje_pkg::ST_FILL_SH: begin
                state_next = col_end ? gje_pkg::ST_CP_RD : gje_pkg::ST_FILL_RD;
            end
            gje_pkg::ST_CP_RD:    state_next = gje_pkg::ST_CP_WR;
            gje_pkg::ST_CP_WR: begin
                state_next = (col_reg == n_eff) ? gje_pkg::ST_NORM : gje_pkg::ST_CP_RD;
            end
            gje_pkg::ST_NORM: begin
                if (norm_act) begin
                    state_next = gje_pkg::ST_NDIV;
                end else if (col_end) begin
                    state_next = skip ? gje_pkg::ST_COL : gje_pkg::ST_EL_T;
                end
            end
            gje_pkg::ST_NDIV: begin
                if (div_res.done) begin
                    state_next = col_end ? gje_pkg::ST_EL_T : gje_pkg::ST_NORM;
                end
            end
            gje_pkg::ST_EL_T: begin
                state_next = (t_reg == n_eff) ? gje_pkg::ST_COL : gje_pkg::ST_EL_F;
            end
            gje_pkg::ST_EL_F:     state_next = gje_pkg::ST_EL_RD;
            gje_pkg::ST_EL_RD:    state_next = gje_pkg::ST_EL_OP;
            gje_pkg::ST_EL_OP: begin
                if (el_act) begin
                    state_next = gje_pkg::ST_EL_MW;
                end else begin
                    state_next = col_end ? gje_pkg::ST_EL_T : gje_pkg::ST_EL_RD;
                end
            end
            gje_pkg::ST_EL_MW: begin
                if (mul_res.done) begin
                    state_next = col_end ? gje_pkg::ST_EL_T : gje_pkg::ST_EL_RD;
                end
            end
            gje_pkg::ST_BS_ROW:   state_next = gje_pkg::ST_BS_X;
            gje_pkg::ST_BS_X:     state_next = gje_pkg::ST_BS_C;
            gje_pkg::ST_BS_C: begin
                if (col_reg == n_eff) begin
                    state_next = (row_reg == '0) ? gje_pkg::ST_OUT : gje_pkg::ST_BS_ROW;
                end else begin
                    state_next = gje_pkg::ST_BS_RD;
                end
            end
            gje_pkg::ST_BS_RD:    state_next = gje_pkg::ST_BS_MW;
            gje_pkg::ST_BS_MW: begin
                if (mul_res.done) begin
                    state_next = gje_pkg::ST_BS_C;
                end
            end
            gje_pkg::ST_OUT: begin
                if (m_ready && out_reg == n_eff - CW'(1)) begin
                    state_next = gje_pkg::ST_IDLE;
                end
            end
            default: state_next = gje_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_of(row_reg, col_reg, w_eff);
        mem_wdata = head;
        mem_raddr = addr_of(row_reg, col_reg, w_eff);
        mul_start = 1'b0;
        div_start = 1'b0;
        shift_en  = 1'b0;
        feed      = head;
        mul_a     = head;
        mul_b     = f_reg;
        case (state_reg)
            gje_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                mem_we    = s_valid && load_ok;
                mem_waddr = load_reg[gje_pkg::ADDR_W-1:0];
                mem_wdata = s_entry_value;
            end
            gje_pkg::ST_SRCH_RD, gje_pkg::ST_SRCH_CMP: begin
                mem_raddr = addr_of(t_reg, row_reg, w_eff);
            end
            gje_pkg::ST_FILL_RD: begin
                mem_raddr = addr_of(bi_reg, col_reg, w_eff);
            end
            gje_pkg::ST_FILL_SH: begin
                shift_en = 1'b1;
                feed     = rdata_reg;
            end
            gje_pkg::ST_CP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(bi_reg, col_reg, w_eff);
                mem_wdata = rdata_reg;
            end
            gje_pkg::ST_NORM: begin
                if (norm_act) begin
                    div_start = 1'b1;
                end else begin
                    shift_en = 1'b1;
                    mem_we   = col_reg < w_eff;
                end
            end
            gje_pkg::ST_NDIV: begin
                if (div_res.done) begin
                    shift_en  = 1'b1;
                    feed      = div_res.value;
                    mem_we    = 1'b1;
                    mem_wdata = div_res.value;
                end
            end
            gje_pkg::ST_EL_T: begin
                mem_raddr = addr_of(t_reg, row_reg, w_eff);
            end
            gje_pkg::ST_EL_RD: begin
                mem_raddr = addr_of(t_reg, col_reg, w_eff);
            end
            gje_pkg::ST_EL_OP: begin
                mem_raddr = addr_of(t_reg, col_reg, w_eff);
                if (el_act) begin
                    mul_start = 1'b1;
                end else begin
                    shift_en = 1'b1;
                end
            end
            gje_pkg::ST_EL_MW: begin
                mem_raddr = addr_of(t_reg, col_reg, w_eff);
                mem_waddr = addr_of(t_reg, col_reg, w_eff);
                mem_wdata = el_diff;
                if (mul_res.done) begin
                    shift_en = 1'b1;
                    mem_we   = 1'b1;
                end
            end
            gje_pkg::ST_BS_ROW: begin
                mem_raddr = addr_of(row_reg, n_eff, w_eff);
            end
            gje_pkg::ST_BS_RD: begin
                mul_start = 1'b1;
                mul_a     = sol_reg[col_reg[gje_pkg::IDX_W-1:0]];
                mul_b     = rdata_reg;
            end
            gje_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                mem_raddr = addr_of(row_reg, col_reg, w_eff);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gje_pkg::ST_IDLE;
            size_reg  <= gje_pkg::SIZE_RESET;
            thr_reg   <= gje_pkg::THRESHOLD_RESET;
            load_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    gje_pkg::CFG_SIZE_IN_USE:     size_reg <= cfg_data[gje_pkg::SIZE_W-1:0];
                    gje_pkg::CFG_PIVOT_THRESHOLD: thr_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == gje_pkg::ST_IDLE && s_valid) begin
                if (s_final_entry) begin
                    load_reg <= '0;
                end else if (load_ok) begin
                    load_reg <= load_reg + gje_pkg::LOAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            gje_pkg::ST_IDLE: begin
                row_reg <= '0;
            end
            gje_pkg::ST_COL: begin
                t_reg <= row_reg;
                if (row_reg == n_eff) begin
                    row_reg <= n_eff - CW'(1);
                end
            end
            gje_pkg::ST_SRCH_CMP: begin
                if (t_reg == row_reg || best_reg < cand_mag) begin
                    best_reg <= cand_mag;
                    bi_reg   <= t_reg;
                    piv_reg  <= rdata_reg;
                end
                t_reg   <= t_reg + CW'(1);
                col_reg <= '0;
            end
            gje_pkg::ST_FILL_SH: begin
                col_reg <= col_end ? '0 : col_reg + CW'(1);
            end
            gje_pkg::ST_CP_WR: begin
                col_reg <= (col_reg == n_eff) ? '0 : col_reg + CW'(1);
            end
            gje_pkg::ST_NORM, gje_pkg::ST_NDIV: begin
                if ((state_reg == gje_pkg::ST_NORM && !norm_act) ||
                    (state_reg == gje_pkg::ST_NDIV && div_res.done)) begin
                    col_reg <= col_end ? '0 : col_reg + CW'(1);
                    if (col_end) begin
                        t_reg <= row_reg + CW'(1);
                        if (skip) begin
                            row_reg <= row_reg + CW'(1);
                        end
                    end
                end
            end
            gje_pkg::ST_EL_T: begin
                col_reg <= '0;
                if (t_reg == n_eff) begin
                    row_reg <= row_reg + CW'(1);
                end
            end
            gje_pkg::ST_EL_F: begin
                f_reg <= rdata_reg;
            end
            gje_pkg::ST_EL_OP, gje_pkg::ST_EL_MW: begin
                if ((state_reg == gje_pkg::ST_EL_OP && !el_act) ||
                    (state_reg == gje_pkg::ST_EL_MW && mul_res.done)) begin
                    col_reg <= col_end ? '0 : col_reg + CW'(1);
                    if (col_end) begin
                        t_reg <= t_reg + CW'(1);
                    end
                end
            end
            gje_pkg::ST_BS_X: begin
                x_reg   <= rdata_reg;
                col_reg <= row_reg + CW'(1);
            end
            gje_pkg::ST_BS_C: begin
                if (col_reg == n_eff) begin
                    sol_reg[row_reg[gje_pkg::IDX_W-1:0]] <= x_reg;
                    out_reg <= '0;
                    if (row_reg != '0) begin
                        row_reg <= row_reg - CW'(1);
                    end
                end
            end
            gje_pkg::ST_BS_MW: begin
                if (mul_res.done) begin
                    x_reg   <= gje_pkg::sub_sat(x_reg, mul_res.value);
                    col_reg <= col_reg + CW'(1);
                end
            end
            gje_pkg::ST_OUT: begin
                if (m_ready) begin
                    out_reg <= out_reg + CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign cfg_ready       = 1'b1;
    assign m_unknown_index = gje_pkg::OUT_IDX_W'(out_reg);
    assign m_unknown_value = sol_reg[out_reg[gje_pkg::IDX_W-1:0]];
    assign m_last_unknown  = out_reg == n_eff - CW'(1);

endmodule

`default_nettype wire

/* src/gje_cell.sv */
// ----------------------------------------------------------------------------
// Gauss elimination row cell
// One word of the pivot row; passes its word to the neighbor on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gje_cell (
    input  wire logic          aclk,
    input  wire logic          shift_en,
    input  wire gje_pkg::word_t din,
    output gje_pkg::word_t      dout
);

    gje_pkg::word_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

/* src/gje_mul.sv */
// ----------------------------------------------------------------------------
// Gauss elimination fixed point multiplier
// Q16.32 product over four half-width partial products, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module gje_mul (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire gje_pkg::word_t  a,
    input  wire gje_pkg::word_t  b,
    output gje_pkg::arith_res_t  res
);

    localparam int W = gje_pkg::WORD_BITS;
    localparam int H = gje_pkg::HALF_BITS;
    localparam int P = 2 * W;

    gje_pkg::mag_t       ua_reg;
    gje_pkg::mag_t       ub_reg;
    logic                neg_reg;
    logic [P-1:0]        acc_reg;
    logic [1:0]          step_reg;
    logic                busy_reg;
    logic                fin_reg;
    gje_pkg::arith_res_t res_reg;

    logic [H-1:0]   a_half;
    logic [H-1:0]   b_half;
    logic [2*H-1:0] pp;
    logic [P-1:0]   term;
    logic           ovf;

    always_comb begin
        a_half = step_reg[0] ? ua_reg[2*H-1:H] : ua_reg[H-1:0];
        b_half = step_reg[1] ? ub_reg[2*H-1:H] : ub_reg[H-1:0];
        pp     = a_half * b_half;
        case (step_reg)
            2'd0:    term = P'(pp);
            2'd3:    term = P'(pp) << (2 * H);
            default: term = P'(pp) << H;
        endcase
        ovf = |acc_reg[P-1:W-1+gje_pkg::FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            res_reg.done <= 1'b0;
        end else begin
            res_reg.done <= 1'b0;
            fin_reg      <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == 2'd3) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
            if (fin_reg) begin
                res_reg.done <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg   <= gje_pkg::mag_of(a);
            ub_reg   <= gje_pkg::mag_of(b);
            neg_reg  <= a[W-1] ^ b[W-1];
            acc_reg  <= '0;
            step_reg <= 2'd0;
        end else if (busy_reg) begin
            acc_reg  <= acc_reg + term;
            step_reg <= step_reg + 2'd1;
        end
        if (fin_reg) begin
            res_reg.value <= gje_pkg::sat_word(neg_reg, ovf,
                acc_reg[W-2+gje_pkg::FRAC_BITS:gje_pkg::FRAC_BITS]);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* src/gje_div.sv */
// ----------------------------------------------------------------------------
// Gauss elimination fixed point divider
// Restoring division, one quotient bit per cycle, Q16.32 result saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module gje_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire gje_pkg::word_t  a,
    input  wire gje_pkg::word_t  b,
    output gje_pkg::arith_res_t  res
);

    localparam int W = gje_pkg::WORD_BITS;
    localparam int D = gje_pkg::DIV_ITER;

    logic [D-1:0]                    dvd_reg;
    gje_pkg::mag_t                   ub_reg;
    gje_pkg::mag_t                   rem_reg;
    gje_pkg::mag_t                   q_reg;
    logic                            sticky_reg;
    logic                            neg_reg;
    logic [gje_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                            busy_reg;
    logic                            fin_reg;
    gje_pkg::arith_res_t             res_reg;

    logic [W:0] r2;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
        r2   = {rem_reg, dvd_reg[D-1]};
        diff = r2 - {1'b0, ub_reg};
        ge   = r2 >= {1'b0, ub_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            res_reg.done <= 1'b0;
        end else begin
            res_reg.done <= fin_reg;
            fin_reg      <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == gje_pkg::DIV_CNT_W'(D - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg    <= {gje_pkg::mag_of(a), {gje_pkg::FRAC_BITS{1'b0}}};
            ub_reg     <= gje_pkg::mag_of(b);
            rem_reg    <= '0;
            q_reg      <= '0;
            sticky_reg <= 1'b0;
            neg_reg    <= a[W-1] ^ b[W-1];
            cnt_reg    <= '0;
        end else if (busy_reg) begin
            dvd_reg    <= {dvd_reg[D-2:0], 1'b0};
            rem_reg    <= ge ? diff[W-1:0] : r2[W-1:0];
            q_reg      <= {q_reg[W-2:0], ge};
            sticky_reg <= sticky_reg | q_reg[W-1];
            cnt_reg    <= cnt_reg + gje_pkg::DIV_CNT_W'(1);
        end
        if (fin_reg) begin
            res_reg.value <= gje_pkg::sat_word(neg_reg, sticky_reg | q_reg[W-1],
                                               q_reg[W-2:0]);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* src/gje_checker.sv */
// ----------------------------------------------------------------------------
// Gauss elimination solver checker
// Port-level checks on the solver's load and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gauss_elimination_solver_core_macros.svh"

module gje_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire gje_pkg::word_t                     s_entry_value,
    input wire logic                               s_final_entry,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [gje_pkg::OUT_IDX_W-1:0]      m_unknown_index,
    input wire gje_pkg::word_t                     m_unknown_value,
    input wire logic                               m_last_unknown,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready,
    input wire logic [gje_pkg::CFG_IDX_W-1:0]      cfg_index,
    input wire logic [gje_pkg::THR_W-1:0]          cfg_data
);

    `GJE_ASSERT_NEVER(a_no_load_while_emit, s_ready && m_valid,
        "load accepted while results are pending")

    `GJE_ASSERT_NEXT(a_final_stalls_input, s_valid && s_ready && s_final_entry,
        !s_ready, "input not stalled after the final beat")

    `GJE_ASSERT_NEXT(a_index_steps, m_valid && m_ready && !m_last_unknown,
        m_valid && m_unknown_index == $past(m_unknown_index) + 3'd1,
        "result index did not advance by one")

    `GJE_ASSERT_NEXT(a_last_ends_run, m_valid && m_ready && m_last_unknown,
        !m_valid, "results continued after the last beat")

    `GJE_ASSERT_NEXT(a_result_held, m_valid && !m_ready,
        m_valid && $stable(m_unknown_value) && $stable(m_unknown_index),
        "stalled result beat changed")

endmodule

bind gauss_elimination_solver_core gje_checker u_gje_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_entry_value   (s_entry_value),
    .s_final_entry   (s_final_entry),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_unknown_index (m_unknown_index),
    .m_unknown_value (m_unknown_value),
    .m_last_unknown  (m_last_unknown),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
);

`default_nettype wire
